[design/sbc_pkg.sv]
package sbc_pkg;

  // Field widths fixed by the interface
  localparam int KEY_W   = 7;
  localparam int COUNT_W = 7;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [COUNT_W-1:0] count_t;

  // One tree node, indexed by its key value. A zero link means no child.
  typedef struct packed {
    logic visited;
    key_t left;
    key_t right;
  } node_t;

  localparam int NODE_W = $bits(node_t);

endpackage

[design/sbc_ram.sv]
module sbc_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 65,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read: data is valid in the cycle after the address
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[design/same_bst_check_unit.sv]
// A reference-key transaction is taken in the idle state. A test key at the
// first position of a round is as well; otherwise an insertion walks the tree
// (one node-memory read per level, then the writes of the link and new node).
// The last test key of a round adds the check: each reference key is searched
// from the root, one read per level through the single node-memory read port.
// rst is synchronous; node entries are zeroed as keys enter the tree, so no
// clearing pass is needed after reset.
module same_bst_check_unit
  import sbc_pkg::*;
#(
  parameter int MAX_KEYS = 64
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   cfg_we,
  input  count_t cfg_wdata,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   func,
  input  key_t   key,
  output logic   out_valid,
  input  logic   out_ready,
  output logic   same_tree
);

  localparam int NODE_DEPTH = MAX_KEYS + 1;
  localparam int NAW        = $clog2(NODE_DEPTH);
  localparam int RAW        = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CapKeys    = (MAX_KEYS < 127) ? MAX_KEYS : 127;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_INS_WALK = 7'b0000010,
    ST_INS_NEW  = 7'b0000100,
    ST_CHK_REF  = 7'b0001000,
    ST_CHK_ROOT = 7'b0010000,
    ST_CHK_WALK = 7'b0100000,
    ST_VERDICT  = 7'b1000000
  } state_t;

  function automatic logic key_ok(key_t k);
    return (k != '0) && (int'(k) <= MAX_KEYS);
  endfunction

  state_t state, state_next;
  count_t key_count;
  count_t ref_pos, ref_pos_next;
  count_t test_pos, test_pos_next;
  count_t chk_idx, chk_idx_next;
  key_t   root, root_next;
  key_t   cur, cur_next;
  key_t   ins_key, ins_key_next;
  key_t   target, target_next;
  logic   chk_pending, chk_pending_next;
  logic   verdict, verdict_next;

  // Memory ports
  logic            node_we;
  logic [NAW-1:0]  node_waddr, node_raddr;
  node_t           node_wdata, node_rd;
  logic [NODE_W-1:0] node_rdata;
  logic            ref_we;
  logic [RAW-1:0]  ref_waddr, ref_raddr;
  key_t            ref_rdata;

  sbc_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  sbc_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (ref_waddr),
    .wdata (key),
    .raddr (ref_raddr),
    .rdata (ref_rdata)
  );

  assign node_rd  = node_t'(node_rdata);
  assign in_ready = (state == ST_IDLE);

  // Effective key count: zero acts as one, clamp to capacity
  count_t count;
  always_comb begin
    if (key_count == '0) begin
      count = count_t'(1);
    end else if (int'(key_count) > CapKeys) begin
      count = count_t'(CapKeys);
    end else begin
      count = key_count;
    end
  end

  // Main sequencer
  count_t rp, rp1, tp, tp1, idx1;
  key_t   link, nxt;
  logic   last;
  always_comb begin
    state_next       = state;
    ref_pos_next     = ref_pos;
    test_pos_next    = test_pos;
    chk_idx_next     = chk_idx;
    root_next        = root;
    cur_next         = cur;
    ins_key_next     = ins_key;
    target_next      = target;
    chk_pending_next = chk_pending;
    verdict_next     = verdict;
    node_we          = 1'b0;
    node_waddr       = NAW'(cur);
    node_wdata       = '0;
    node_raddr       = NAW'(cur);
    ref_we           = 1'b0;
    ref_raddr        = RAW'(chk_idx);
    rp   = (ref_pos >= count) ? '0 : ref_pos;
    rp1  = rp + count_t'(1);
    ref_waddr = RAW'(rp);
    tp   = (test_pos >= count) ? '0 : test_pos;
    tp1  = tp + count_t'(1);
    last = (tp1 >= count);
    idx1 = chk_idx + count_t'(1);
    link = (ins_key < cur) ? node_rd.left : node_rd.right;
    nxt  = (target > cur) ? node_rd.right : node_rd.left;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (!func) begin
            // store reference key
            ref_we       = 1'b1;
            ref_pos_next = (rp1 >= count) ? '0 : rp1;
          end else begin
            test_pos_next    = last ? '0 : tp1;
            chk_pending_next = last;
            chk_idx_next     = '0;
            if (tp == '0) begin
              // new round: a valid key becomes the root with a fresh entry
              if (key_ok(key)) begin
                root_next  = key;
                node_we    = 1'b1;
                node_waddr = NAW'(key);
                node_wdata = '0;
              end else begin
                root_next = '0;
              end
              state_next = last ? ST_CHK_REF : ST_IDLE;
            end else if (key_ok(key) && key_ok(root)) begin
              cur_next     = root;
              node_raddr   = NAW'(root);
              ins_key_next = key;
              state_next   = ST_INS_WALK;
            end else begin
              state_next = last ? ST_CHK_REF : ST_IDLE;
            end
          end
        end
      end

      ST_INS_WALK: begin
        if (cur == ins_key) begin
          // already in the tree
          state_next = chk_pending ? ST_CHK_REF : ST_IDLE;
        end else if (link == '0) begin
          // attach new key to this node
          node_we    = 1'b1;
          node_waddr = NAW'(cur);
          node_wdata = node_rd;
          if (ins_key < cur) begin
            node_wdata.left = ins_key;
          end else begin
            node_wdata.right = ins_key;
          end
          state_next = ST_INS_NEW;
        end else begin
          cur_next   = link;
          node_raddr = NAW'(link);
        end
      end

      ST_INS_NEW: begin
        // fresh entry for the new node
        node_we    = 1'b1;
        node_waddr = NAW'(ins_key);
        node_wdata = '0;
        state_next = chk_pending ? ST_CHK_REF : ST_IDLE;
      end

      ST_CHK_REF: begin
        // reference key read issued
        state_next = ST_CHK_ROOT;
      end

      ST_CHK_ROOT: begin
        target_next = ref_rdata;
        if (key_ok(root)) begin
          cur_next   = root;
          node_raddr = NAW'(root);
          state_next = ST_CHK_WALK;
        end else begin
          verdict_next = 1'b0;
          state_next   = ST_VERDICT;
        end
      end

      ST_CHK_WALK: begin
        if (cur == target) begin
          // found: mark visited
          node_we            = 1'b1;
          node_waddr         = NAW'(cur);
          node_wdata         = node_rd;
          node_wdata.visited = 1'b1;
          if (idx1 >= count) begin
            verdict_next = 1'b1;
            state_next   = ST_VERDICT;
          end else begin
            chk_idx_next = idx1;
            state_next   = ST_CHK_REF;
          end
        end else if (!node_rd.visited || nxt == '0) begin
          verdict_next = 1'b0;
          state_next   = ST_VERDICT;
        end else begin
          cur_next   = nxt;
          node_raddr = NAW'(nxt);
        end
      end

      ST_VERDICT: begin
        if (!out_valid || out_ready) begin
          chk_pending_next = 1'b0;
          state_next       = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      key_count   <= count_t'(1);
      ref_pos     <= '0;
      test_pos    <= '0;
      chk_idx     <= '0;
      root        <= '0;
      chk_pending <= 1'b0;
    end else begin
      state       <= state_next;
      ref_pos     <= ref_pos_next;
      test_pos    <= test_pos_next;
      chk_idx     <= chk_idx_next;
      root        <= root_next;
      chk_pending <= chk_pending_next;
      if (cfg_we) begin
        key_count <= cfg_wdata;
      end
    end
  end

  // Walk datapath registers
  always_ff @(posedge clk) begin
    cur     <= cur_next;
    ins_key <= ins_key_next;
    target  <= target_next;
    verdict <= verdict_next;
  end

  // Output register
  logic load_out;
  assign load_out = (state == ST_VERDICT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      same_tree <= verdict;
    end
  end

endmodule

[design/sbc_checker.sv]
module sbc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic func,
  input logic out_valid,
  input logic out_ready,
  input logic same_tree
);

  // Stalled verdict holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(same_tree))
    else $error("verdict dropped or changed while stalled");

  // After a reference transaction the input is ready again in the next cycle
  a_ref_single: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !func |=> in_ready)
    else $error("input stalled after reference transaction");

  // A verdict only appears out of a check, while input is held off
  a_out_from_check: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("verdict appeared without a check");

  // Reset leaves no verdict pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("verdict pending after reset");

endmodule

bind same_bst_check_unit sbc_checker u_sbc_checker (.*);

[tb/same_bst_check_unit_tb.sv]
module same_bst_check_unit_tb;
  import sbc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_LIMIT     = 64;
  localparam int ITEM_TARGET   = 900;
  localparam int TAIL_ITEMS    = 100;
  localparam int SETTLE_CYCLES = 150;
  localparam int DRAIN_CYCLES  = 300;
  localparam int HANG_LIMIT    = 20000;
  localparam int BACKUP_AT     = 400;
  localparam int BACKUP_CYCLES = 2000;
  localparam int REPORT_CAP    = 100;

  // Transaction kinds on the input channel
  localparam logic OP_STORE_REF   = 1'b0;
  localparam logic OP_INSERT_TEST = 1'b1;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum int {SPOIL_SWAP, SPOIL_STRAY, SPOIL_DUP, SPOIL_OTHER} spoil_t;

  typedef key_t key_list_t [$];

  typedef struct packed {
    row_kind_t kind;
    logic      op;
    key_t      val;
    logic      typed;
    logic      want;
  } plan_row_t;

  // Directed opening: extremes, stray keys, duplicates, count clamping, shrink mid-round
  localparam int PLAN_ROWS = 28;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_ITEM, OP_STORE_REF,   7'd1,   1'b0, 1'b0},
    '{ROW_ITEM, OP_INSERT_TEST, 7'd1,   1'b1, 1'b1},
    '{ROW_ITEM, OP_INSERT_TEST, 7'd64,  1'b1, 1'b0},
    '{ROW_ITEM, OP_STORE_REF,   7'd64,  1'b0, 1'b0},
    '{ROW_ITEM, OP_INSERT_TEST, 7'd64,  1'b1, 1'b1},
    '{ROW_ITEM, OP_INSERT_TEST, 7'd0,   1'b1, 1'b0},
    '{ROW_ITEM, OP_INSERT_TEST, 7'd127, 1'b1, 1'b0},
    '{ROW_ITEM, OP_STORE_REF,   7'd127, 1'b0, 1'b0},
    '{ROW_ITEM, OP_INSERT_TEST, 7'd127, 1'b1, 1'b0},
    '{ROW_CFG,  OP_STORE_REF,   7'd0,   1'b0, 1'b0},
    '{ROW_ITEM, OP_STORE_REF,   7'd2,   1'b0, 1'b0},
    '{ROW_ITEM, OP_INSERT_TEST, 7'd2,   1'b1, 1'b1},
    '{ROW_CFG,  OP_STORE_REF,   7'd3,   1'b0, 1'b0},
    '{ROW_ITEM, OP_STORE_REF,   7'd2,   1'b0, 1'b0},
    '{ROW_ITEM, OP_STORE_REF,   7'd1,   1'b0, 1'b0},
    '{ROW_ITEM, OP_STORE_REF,   7'd3,   1'b0, 1'b0},
    '{ROW_ITEM, OP_INSERT_TEST, 7'd2,   1'b0, 1'b0},
    '{ROW_ITEM, OP_INSERT_TEST, 7'd3,   1'b0, 1'b0},
    '{ROW_ITEM, OP_INSERT_TEST, 7'd1,   1'b0, 1'b0},
    '{ROW_ITEM, OP_INSERT_TEST, 7'd2,   1'b0, 1'b0},
    '{ROW_ITEM, OP_INSERT_TEST, 7'd2,   1'b0, 1'b0},
    '{ROW_ITEM, OP_INSERT_TEST, 7'd1,   1'b0, 1'b0},
    '{ROW_ITEM, OP_INSERT_TEST, 7'd2,   1'b0, 1'b0},
    '{ROW_ITEM, OP_INSERT_TEST, 7'd0,   1'b0, 1'b0},
    '{ROW_ITEM, OP_INSERT_TEST, 7'd3,   1'b0, 1'b0},
    '{ROW_ITEM, OP_INSERT_TEST, 7'd1,   1'b0, 1'b0},
    '{ROW_CFG,  OP_STORE_REF,   7'd1,   1'b0, 1'b0},
    '{ROW_ITEM, OP_INSERT_TEST, 7'd2,   1'b0, 1'b0}
  };

  logic   clk;
  logic   rst       = 1'b1;
  logic   cfg_we    = 1'b0;
  count_t cfg_wdata = '0;
  logic   in_valid  = 1'b0;
  logic   in_ready;
  logic   func      = 1'b0;
  key_t   key       = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic   same_tree;

  same_bst_check_unit #(
    .MAX_KEYS(KEY_LIMIT)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .key      (key),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .same_tree(same_tree)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Shared run control
  bit pending_verdicts [$];
  int sent       = 0;
  int mismatches = 0;
  bit gaps_on    = 1'b1;
  bit tail_mode  = 1'b0;
  bit backup_req  = 1'b0;
  bit backup_done = 1'b0;

  // Queue one predicted verdict
  function automatic void queue_verdict(input bit v);
    pending_verdicts.insert(pending_verdicts.size(), v);
  endfunction

  // Append one key at the back of a key list
  function automatic void add_key(ref key_list_t q, input key_t k);
    q.insert(q.size(), k);
  endfunction

  // ---------------------------------------------------------------
  // Tree predictor: mirrored state and key_count register
  // ---------------------------------------------------------------
  count_t      count_reg = 7'd1;
  key_t        ref_keys [KEY_LIMIT]   = '{default: '0};
  key_t        lo_link  [KEY_LIMIT+1] = '{default: '0};
  key_t        hi_link  [KEY_LIMIT+1] = '{default: '0};
  bit          in_tree  [KEY_LIMIT+1] = '{default: 1'b0};
  key_t        tree_root = '0;
  int unsigned ref_pos   = 0;
  int unsigned test_pos  = 0;

  function automatic int unsigned eff_count();
    if (count_reg == 0) return 1;
    if (count_reg > KEY_LIMIT) return KEY_LIMIT;
    return count_reg;
  endfunction

  function automatic bit key_ok(input int unsigned k);
    return k >= 1 && k <= KEY_LIMIT;
  endfunction

  // Insert below the root; equal-or-greater goes right, present keys are dropped
  function automatic void tree_insert(input key_t x);
    key_t node;
    key_t nxt;
    node = tree_root;
    if (!key_ok(x) || !key_ok(node) || in_tree[x]) return;
    for (int s = 0; s <= KEY_LIMIT; s++) begin
      nxt = (x < node) ? lo_link[node] : hi_link[node];
      if (nxt == 0) begin
        if (x < node) lo_link[node] = x;
        else hi_link[node] = x;
        in_tree[x] = 1'b1;
        return;
      end
      node = nxt;
      if (!key_ok(node)) return;
    end
  endfunction

  // Search every reference key; stepping through an unseen node or off the tree fails
  function automatic bit tree_verdict(input int unsigned n);
    bit   seen [KEY_LIMIT+1];
    key_t node;
    key_t target;
    bit   found;
    seen = '{default: 1'b0};
    for (int i = 0; i < n; i++) begin
      target = ref_keys[i];
      node   = tree_root;
      found  = 1'b0;
      for (int s = 0; s <= KEY_LIMIT; s++) begin
        if (!key_ok(node)) return 1'b0;
        if (node == target) begin
          seen[node] = 1'b1;
          found = 1'b1;
          break;
        end
        if (!seen[node]) return 1'b0;
        node = (target > node) ? hi_link[node] : lo_link[node];
      end
      if (!found) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void bst_step(input logic op, input key_t k,
                                   output bit has, output bit verdict);
    int unsigned n;
    n = eff_count();
    has = 1'b0;
    verdict = 1'b0;
    if (op == OP_STORE_REF) begin
      if (ref_pos >= n) ref_pos = 0;
      ref_keys[ref_pos] = k;
      ref_pos++;
      if (ref_pos >= n) ref_pos = 0;
      return;
    end
    if (test_pos >= n) test_pos = 0;
    if (test_pos == 0) begin
      lo_link = '{default: '0};
      hi_link = '{default: '0};
      in_tree = '{default: 1'b0};
      if (key_ok(k)) begin
        tree_root = k;
        in_tree[k] = 1'b1;
      end else begin
        tree_root = '0;
      end
    end else begin
      tree_insert(k);
    end
    test_pos++;
    if (test_pos >= n) begin
      test_pos = 0;
      has = 1'b1;
      verdict = tree_verdict(n);
    end
  endfunction

  // ---------------------------------------------------------------
  // Key sequence generators
  // ---------------------------------------------------------------
  function automatic key_list_t shuffle_keys(input key_list_t q);
    key_t t;
    int   j;
    for (int i = q.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = q[i];
      q[i] = q[j];
      q[j] = t;
    end
    return q;
  endfunction

  // n distinct keys: either 1..n or drawn from the whole key range
  function automatic key_list_t make_key_set(input int unsigned n);
    key_list_t pool;
    int unsigned top;
    top = ($urandom_range(0, 1) == 0) ? n : KEY_LIMIT;
    for (int i = 1; i <= top; i++) add_key(pool, key_t'(i));
    pool = shuffle_keys(pool);
    while (pool.size() > n) void'(pool.pop_back());
    return pool;
  endfunction

  function automatic key_t stray_key();
    if ($urandom_range(0, 1) == 0) return '0;
    return key_t'($urandom_range(KEY_LIMIT + 1, 127));
  endfunction

  // Another insertion order giving the same tree: parents always come first
  function automatic key_list_t tree_order(input key_list_t src);
    key_t        lo [KEY_LIMIT+1];
    key_t        hi [KEY_LIMIT+1];
    key_list_t   open_q;
    key_list_t   dst;
    key_t        node;
    key_t        x;
    int unsigned idx;
    lo = '{default: '0};
    hi = '{default: '0};
    for (int i = 1; i < src.size(); i++) begin
      node = src[0];
      forever begin
        if (src[i] < node) begin
          if (lo[node] == 0) begin
            lo[node] = src[i];
            break;
          end
          node = lo[node];
        end else begin
          if (hi[node] == 0) begin
            hi[node] = src[i];
            break;
          end
          node = hi[node];
        end
      end
    end
    add_key(open_q, src[0]);
    while (open_q.size() != 0) begin
      idx = $urandom_range(0, open_q.size() - 1);
      x = open_q[idx];
      open_q.delete(idx);
      add_key(dst, x);
      if (lo[x] != 0) add_key(open_q, lo[x]);
      if (hi[x] != 0) add_key(open_q, hi[x]);
    end
    return dst;
  endfunction

  // Spoil a sequence: swap two entries, or overwrite one with a stray, repeated or random key
  function automatic key_list_t spoil_order(input key_list_t q);
    int unsigned p;
    int unsigned r;
    key_t        t;
    p = $urandom_range(0, q.size() - 1);
    r = $urandom_range(0, q.size() - 1);
    case (spoil_t'($urandom_range(0, 3)))
      SPOIL_SWAP: begin
        t = q[p];
        q[p] = q[r];
        q[r] = t;
      end
      SPOIL_STRAY: q[p] = stray_key();
      SPOIL_DUP:   q[p] = q[r];
      default:     q[p] = key_t'($urandom_range(1, KEY_LIMIT));
    endcase
    return q;
  endfunction

  // ---------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------
  task automatic offer_key(input logic op, input key_t k, input bit typed, input bit want);
    bit has;
    bit verdict;
    if (gaps_on && !tail_mode && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= op;
    key      <= k;
    do @(posedge clk); while (!in_ready);
    bst_step(op, k, has, verdict);
    if (has) queue_verdict(typed ? want : verdict);
    sent++;
    tail_mode = (sent + TAIL_ITEMS >= ITEM_TARGET);
  endtask

  // Wait for the block to go idle, then write key_count
  task automatic write_key_count(input count_t v);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    count_reg = v;
  endtask

  // Reference keys are written rotated so that entry i ends up holding p[i]
  task automatic load_reference(input key_list_t p);
    int unsigned n;
    int unsigned start;
    n = p.size();
    start = (ref_pos >= n) ? 0 : ref_pos;
    for (int i = 0; i < n; i++) offer_key(OP_STORE_REF, p[(start + i) % n], 1'b0, 1'b0);
  endtask

  task automatic run_round(input key_list_t t);
    foreach (t[i]) offer_key(OP_INSERT_TEST, t[i], 1'b0, 1'b0);
  endtask

  // ---------------------------------------------------------------
  // Output side: random stalls plus one long backup
  // ---------------------------------------------------------------
  initial begin
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (!backup_done && backup_req) begin
        out_ready <= 1'b0;
        repeat (BACKUP_CYCLES) @(posedge clk);
        backup_done = 1'b1;
        out_ready <= 1'b1;
      end else if (gaps_on && !tail_mode && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatches < REPORT_CAP) $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Verdict checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("same_tree=%0b with no verdict pending", same_tree));
      end else if (same_tree !== pending_verdicts[0]) begin
        report_mismatch($sformatf("same_tree got %0b want %0b", same_tree,
                                  pending_verdicts[0]));
        void'(pending_verdicts.pop_front());
      end else begin
        void'(pending_verdicts.pop_front());
      end
    end
  end

  // Hang detection: cycles without any transaction on either channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------
  initial begin
    key_list_t   ref_set;
    key_list_t   order;
    int unsigned n;
    int unsigned rounds;
    int unsigned pick;
    int unsigned cut;
    int          phase;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_CFG) write_key_count(PLAN[i].val);
      else offer_key(PLAN[i].op, PLAN[i].val, PLAN[i].typed, PLAN[i].want);
    end

    // random phases, each with its own key_count
    phase = 0;
    while (sent < ITEM_TARGET) begin
      case (phase)
        0: write_key_count(7'd127);
        1: write_key_count(7'd64);
        3: write_key_count(7'd0);
        default: begin
          pick = $urandom_range(0, 9);
          if (pick < 7) write_key_count(count_t'($urandom_range(2, 8)));
          else if (pick < 9) write_key_count(count_t'($urandom_range(9, 20)));
          else write_key_count(7'd1);
        end
      endcase
      n = eff_count();
      gaps_on = ($urandom_range(0, 3) != 0);

      // phase 1 uses the sorted order: a single chain at full depth
      if (phase == 1) begin
        ref_set.delete();
        for (int i = 1; i <= n; i++) add_key(ref_set, key_t'(i));
      end else begin
        ref_set = make_key_set(n);
      end
      load_reference(ref_set);

      // long output stall: two full rounds pile up behind the held verdict
      if (!backup_done && !backup_req && sent >= BACKUP_AT) begin
        backup_req = 1'b1;
        run_round(tree_order(ref_set));
        run_round(tree_order(ref_set));
      end

      rounds = (n > 16) ? 1 : $urandom_range(2, 6);
      for (int r = 0; r < rounds; r++) begin
        pick = (n > 16) ? 0 : $urandom_range(0, 9);
        if (pick < 5) begin
          run_round(tree_order(ref_set));
        end else if (pick < 7) begin
          run_round(shuffle_keys(ref_set));
        end else if (pick < 9) begin
          run_round(spoil_order(tree_order(ref_set)));
        end else begin
          // new reference, sometimes spoiled: two keys swapped, or one replaced by a stray, repeated or random key
          ref_set = make_key_set(n);
          if ($urandom_range(0, 1) == 0) load_reference(spoil_order(ref_set));
          else load_reference(ref_set);
        end
      end

      // leave a round or a reference partly done before the next count change
      if (n > 1 && $urandom_range(0, 2) == 0) begin
        cut = $urandom_range(1, n - 1);
        order = shuffle_keys(ref_set);
        pick = $urandom_range(0, 1);
        for (int i = 0; i < cut; i++) begin
          offer_key(pick ? OP_INSERT_TEST : OP_STORE_REF, order[i], 1'b0, 1'b0);
        end
      end
      phase++;
    end

    // drain
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
